FILE: rtl/core/msro_pkg.sv
// Shared types, constants and helper functions of the mass-spring ring oscillator.
package msro_pkg;

  localparam int MAX_WEIGHTS_DEF = 64;
  localparam int RING_MIN        = 4;

  // configuration register indexes
  localparam logic [2:0] REG_RING_SIZE   = 3'd0;
  localparam logic [2:0] REG_SPRING      = 3'd1;
  localparam logic [2:0] REG_DAMPING     = 3'd2;
  localparam logic [2:0] REG_INV_MASS    = 3'd3;
  localparam logic [2:0] REG_TIME_STEP   = 3'd4;
  localparam logic [2:0] REG_SCAN_INCR   = 3'd5;

  localparam int RING_SIZE_RST            = 64;
  localparam logic [23:0] SPRING_RST      = 24'd131072;
  localparam logic [23:0] DAMPING_RST     = 24'd16384;
  localparam logic [23:0] INV_MASS_RST    = 24'd1310720;
  localparam logic [15:0] TIME_STEP_RST   = 16'd655;
  localparam logic [15:0] SCAN_INCR_RST   = 16'd0;

  // start-up sine table generation
  localparam int SINE_ONE     = 65536;
  localparam int SINE_PI      = 205887;
  localparam int SINE_HALF_PI = 102944;
  localparam int SINE_SPAN    = 408814;
  localparam int SINE_TERMS   = 5;
  localparam int RECIP_SHIFT  = 25;

  localparam int DAC_MID = 2048;
  localparam int DAC_MAX = 4095;

  localparam logic signed [63:0] Q_MAX = 64'sd8388607;
  localparam logic signed [63:0] Q_MIN = -64'sd8388608;

  typedef enum logic [1:0] {
    OPER_SAMPLE  = 2'd0,
    OPER_PHYSICS = 2'd1,
    OPER_PLUCK   = 2'd2,
    OPER_EXCITE  = 2'd3
  } oper_t;

  typedef enum logic [5:0] {
    ST_INI_START, ST_INI_SQ, ST_INI_X2, ST_INI_TMUL, ST_INI_DIV,
    ST_INI_TUPD, ST_INI_XT, ST_INI_WR, ST_INI_ZERO,
    ST_IDLE,
    ST_SM_PTR, ST_SM_RDI, ST_SM_RDJ, ST_SM_MUL, ST_SM_OUT,
    ST_V_RD, ST_V_MUL, ST_V_WR,
    ST_P_RD, ST_P_MUL, ST_P_WR,
    ST_A_RD0, ST_A_RDL, ST_A_INIT, ST_A_RD, ST_A_DIFF, ST_A_MK, ST_A_MZ,
    ST_A_F, ST_A_MH, ST_A_ML, ST_A_WR,
    ST_PL_RD, ST_PL_WR, ST_EX_RD, ST_EX_WR
  } state_t;

  typedef enum logic [5:0] {
    OP_NOP,
    OP_INI_START, OP_INI_SQ, OP_INI_X2, OP_INI_TMUL, OP_INI_DIV,
    OP_INI_TUPD, OP_INI_XT, OP_INI_WR, OP_INI_ZERO,
    OP_SM_PTR, OP_SM_RDI, OP_SM_RDJ, OP_SM_MUL, OP_SM_OUT,
    OP_V_RD, OP_V_MUL, OP_V_WR,
    OP_P_RD, OP_P_MUL, OP_P_WR,
    OP_A_RD0, OP_A_RDL, OP_A_INIT, OP_A_RD, OP_A_DIFF, OP_A_MK, OP_A_MZ,
    OP_A_F, OP_A_MH, OP_A_ML, OP_A_WR,
    OP_PL_RD, OP_PL_WR, OP_EX_RD, OP_EX_WR
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [2:0] k;
    logic       latch;
  } dp_cmd_t;

  // ceil(2^25/d) for the series divisors 110, 72, 42, 20, 6; exact below 2^18
  function automatic logic [22:0] sine_recip(input logic [2:0] k);
    unique case (k)
      3'd0:    return 23'd305041;
      3'd1:    return 23'd466034;
      3'd2:    return 23'd798916;
      3'd3:    return 23'd1677722;
      default: return 23'd5592406;
    endcase
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [63:0] x);
    if (x > Q_MAX) return 24'sh7FFFFF;
    if (x < Q_MIN) return -24'sh800000;
    return x[23:0];
  endfunction

endpackage

FILE: rtl/core/mass_spring_ring_oscillator.sv
// Mass-spring ring oscillator top level: controller plus datapath.
// Each word runs to completion before the next is accepted, its steps serialised
// by the one shared multiplier and the single read port of each state memory:
// a sample request also waits for the output register to empty, a pluck or excite
// reads and writes one mass, and a physics step updates the velocities, then the
// positions, then the accelerations of all masses of the active ring. After reset the
// block fills its memories before taking the first word: a sine position for each of
// the first min(MAX_WEIGHTS,64) masses (sine by polynomial, the series divisions
// done by reciprocal multiplication) and zeros for each further mass.
// Configuration writes take effect at once; make them only while no word is in
// progress.
module mass_spring_ring_oscillator #(
  parameter int MAX_WEIGHTS = msro_pkg::MAX_WEIGHTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               op_valid,
  output logic               op_stall,
  input  logic [1:0]         operation,
  input  logic [5:0]         weight_index,
  input  logic signed [23:0] amount,
  output logic               dac_valid,
  input  logic               dac_stall,
  output logic [11:0]        dac_code
);
  import msro_pkg::*;

  localparam int IW = $clog2(MAX_WEIGHTS);

  dp_cmd_t       cmd;
  logic [IW-1:0] idx, n_m1;

  msro_ctrl #(.MAX_WEIGHTS(MAX_WEIGHTS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_stall  (op_stall),
    .operation (operation),
    .dac_valid (dac_valid),
    .dac_stall (dac_stall),
    .n_m1      (n_m1),
    .cmd       (cmd),
    .idx       (idx)
  );

  msro_dp #(.MAX_WEIGHTS(MAX_WEIGHTS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .weight_index (weight_index),
    .amount       (amount),
    .cmd          (cmd),
    .idx          (idx),
    .n_m1         (n_m1),
    .dac_code     (dac_code)
  );

endmodule

FILE: rtl/core/msro_ram.sv
// Generic single-write, single-read RAM with registered read data.
module msro_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/msro_dp.sv
// Datapath: configuration registers, state memories and the shared multiplier.
module msro_dp #(
  parameter int MAX_WEIGHTS = msro_pkg::MAX_WEIGHTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [2:0]                     cfg_index,
  input  logic [23:0]                    cfg_data,
  input  logic [5:0]                     weight_index,
  input  logic signed [23:0]             amount,
  input  msro_pkg::dp_cmd_t              cmd,
  input  logic [$clog2(MAX_WEIGHTS)-1:0] idx,
  output logic [$clog2(MAX_WEIGHTS)-1:0] n_m1,
  output logic [11:0]                    dac_code
);
  import msro_pkg::*;

  localparam int IW = $clog2(MAX_WEIGHTS);
  localparam int NW = $clog2(MAX_WEIGHTS + 1);
  localparam int CW = (NW > 7) ? NW : 7;
  localparam int N0 = (MAX_WEIGHTS < RING_SIZE_RST) ? MAX_WEIGHTS : RING_SIZE_RST;
  localparam int THETA_Q = SINE_SPAN / N0;
  localparam int THETA_R = SINE_SPAN % N0;

  logic [6:0]  ring_size;
  logic [23:0] stiffness, damping, inv_mass;
  logic [15:0] time_step, scan_incr, scan_phase;

  logic [5:0]         item_idx;
  logic signed [23:0] item_amt;
  logic [IW-1:0]      item_addr;
  logic               idx_ok;

  logic signed [60:0] prod;
  logic signed [35:0] mul_a;
  logic signed [24:0] mul_b;
  logic               mul_en;

  logic signed [23:0] hold, pcur, pnext;
  logic signed [24:0] dprev, dcur;
  logic signed [25:0] dd;
  logic signed [35:0] f;
  logic signed [47:0] acc;

  logic [18:0] theta, xs;
  logic [7:0]  trem, rsum;
  logic        carry;
  logic [16:0] x_fold, t;
  logic        neg;
  logic [17:0] x2;
  logic [22:0] recip;

  logic [CW-1:0] rs_ext;
  logic [NW-1:0] n_act;

  logic signed [23:0] p_rd, v_rd, a_rd;
  logic signed [23:0] p_wdata, v_wdata, a_wdata;
  logic signed [23:0] v_new, p_new, a_new, pl_new, ex_new, sine_pos;
  logic               p_we, v_we, a_we;
  logic [IW-1:0]      p_raddr, v_raddr, a_raddr, waddr;
  logic [IW-1:0]      smp_i, smp_j;
  logic signed [24:0] d_now;
  logic signed [63:0] s64, c64;
  logic [11:0]        code;

  // effective ring size
  always_comb begin
    rs_ext = CW'(ring_size);
    priority if (rs_ext < CW'(RING_MIN)) begin
      n_act = NW'(RING_MIN);
    end else if (rs_ext > CW'(MAX_WEIGHTS)) begin
      n_act = NW'(MAX_WEIGHTS);
    end else begin
      n_act = NW'(rs_ext);
    end
  end

  assign n_m1      = IW'(n_act - NW'(1));
  assign idx_ok    = CW'(item_idx) < CW'(n_act);
  assign item_addr = IW'(item_idx);

  // sine argument folding
  always_comb begin
    xs  = theta;
    neg = 1'b0;
    if (xs > 19'(SINE_PI)) begin
      xs  = xs - 19'(SINE_PI);
      neg = 1'b1;
    end
    if (xs > 19'(SINE_HALF_PI)) begin
      xs = 19'(SINE_PI) - xs;
    end
    x_fold = 17'(xs);
  end

  assign recip  = sine_recip(cmd.k);
  assign rsum   = trem + 8'(THETA_R);
  assign carry  = rsum >= 8'(N0);

  assign smp_i = prod[16 +: IW];
  assign smp_j = (smp_i == n_m1) ? '0 : IW'(smp_i + 1'b1);
  assign d_now = 25'(p_rd) - 25'(pcur);

  assign v_new    = sat24(64'(hold) + 64'(prod >>> 16));
  assign p_new    = v_new;
  assign a_new    = sat24(((64'(acc) <<< 12) + 64'(prod)) >>> 16);
  assign pl_new   = sat24(64'(p_rd) + 64'(item_amt));
  assign ex_new   = sat24(64'(a_rd) + 64'(item_amt));
  assign sine_pos = neg ? -$signed(24'(prod[32:16])) : $signed(24'(prod[32:16]));

  always_comb begin
    s64 = 64'(pcur) + 64'(prod >>> 16);
    c64 = (s64 >>> 7) + 64'(DAC_MID);
    priority if (c64 < 64'sd0) begin
      code = '0;
    end else if (c64 > 64'(DAC_MAX)) begin
      code = 12'(DAC_MAX);
    end else begin
      code = c64[11:0];
    end
  end

  // multiplier operand select
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (cmd.op)
      OP_INI_SQ: begin
        mul_a = 36'(x_fold);
        mul_b = 25'(x_fold);
      end
      OP_INI_TMUL: begin
        mul_a = 36'(x2);
        mul_b = 25'(t);
      end
      OP_INI_DIV: begin
        mul_a = 36'(prod[33:16]);
        mul_b = 25'(recip);
      end
      OP_INI_XT: begin
        mul_a = 36'(x_fold);
        mul_b = 25'(t);
      end
      OP_SM_PTR: begin
        mul_a = 36'(scan_phase);
        mul_b = 25'(n_act);
      end
      OP_SM_MUL: begin
        mul_a = 36'(d_now);
        mul_b = 25'(prod[15:0]);
      end
      OP_V_MUL: begin
        mul_a = 36'(a_rd);
        mul_b = 25'(time_step);
      end
      OP_P_MUL: begin
        mul_a = 36'(v_rd);
        mul_b = 25'(time_step);
      end
      OP_A_MK: begin
        mul_a = 36'(dd);
        mul_b = 25'(stiffness);
      end
      OP_A_MZ: begin
        mul_a = 36'(hold);
        mul_b = 25'(damping);
      end
      OP_A_MH: begin
        mul_a = f;
        mul_b = 25'(inv_mass[23:12]);
      end
      OP_A_ML: begin
        mul_a = f;
        mul_b = 25'(inv_mass[11:0]);
      end
      default: mul_en = 1'b0;
    endcase
  end

  // memory port control
  always_comb begin
    p_raddr = idx;
    v_raddr = idx;
    a_raddr = idx;
    waddr   = idx;
    p_we    = 1'b0;
    v_we    = 1'b0;
    a_we    = 1'b0;
    p_wdata = p_new;
    v_wdata = v_new;
    a_wdata = a_new;
    unique case (cmd.op)
      OP_INI_WR: begin
        p_we    = 1'b1;
        v_we    = 1'b1;
        a_we    = 1'b1;
        p_wdata = sine_pos;
        v_wdata = '0;
        a_wdata = '0;
      end
      OP_INI_ZERO: begin
        p_we    = 1'b1;
        v_we    = 1'b1;
        a_we    = 1'b1;
        p_wdata = '0;
        v_wdata = '0;
        a_wdata = '0;
      end
      OP_SM_RDI: p_raddr = smp_i;
      OP_SM_RDJ: p_raddr = smp_j;
      OP_V_WR:   v_we = 1'b1;
      OP_P_WR:   p_we = 1'b1;
      OP_A_RD0:  p_raddr = '0;
      OP_A_RDL:  p_raddr = n_m1;
      OP_A_RD:   p_raddr = (idx == n_m1) ? '0 : IW'(idx + 1'b1);
      OP_A_WR:   a_we = 1'b1;
      OP_PL_RD:  p_raddr = item_addr;
      OP_PL_WR: begin
        waddr   = item_addr;
        p_we    = idx_ok;
        p_wdata = pl_new;
      end
      OP_EX_RD:  a_raddr = item_addr;
      OP_EX_WR: begin
        waddr   = item_addr;
        a_we    = idx_ok;
        a_wdata = ex_new;
      end
      default: ;
    endcase
  end

  // configuration and scan phase
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size  <= 7'(RING_SIZE_RST);
      stiffness  <= SPRING_RST;
      damping    <= DAMPING_RST;
      inv_mass   <= INV_MASS_RST;
      time_step  <= TIME_STEP_RST;
      scan_incr  <= SCAN_INCR_RST;
      scan_phase <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_RING_SIZE:  ring_size  <= cfg_data[6:0];
          REG_SPRING:     stiffness  <= cfg_data;
          REG_DAMPING:    damping    <= cfg_data;
          REG_INV_MASS:   inv_mass   <= cfg_data;
          REG_TIME_STEP:  time_step  <= cfg_data[15:0];
          REG_SCAN_INCR:  scan_incr  <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.op == OP_SM_OUT) begin
        scan_phase <= scan_phase + scan_incr;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.latch) begin
      item_idx <= weight_index;
      item_amt <= amount;
    end
    unique case (cmd.op)
      OP_INI_START: begin
        theta <= '0;
        trem  <= '0;
      end
      OP_INI_X2: begin
        x2 <= prod[33:16];
        t  <= 17'(SINE_ONE);
      end
      OP_INI_TUPD: t <= 17'(18'(SINE_ONE) - prod[RECIP_SHIFT +: 18]);
      OP_INI_WR: begin
        theta <= theta + 19'(THETA_Q) + 19'(carry);
        trem  <= carry ? rsum - 8'(N0) : rsum;
      end
      OP_SM_RDJ: pcur <= p_rd;
      OP_SM_OUT: dac_code <= code;
      OP_V_MUL:  hold <= v_rd;
      OP_P_MUL:  hold <= p_rd;
      OP_A_RDL:  pcur <= p_rd;
      OP_A_INIT: dprev <= 25'(pcur) - 25'(p_rd);
      OP_A_DIFF: begin
        dd    <= 26'(d_now) - 26'(dprev);
        dcur  <= d_now;
        hold  <= v_rd;
        pnext <= p_rd;
      end
      OP_A_MZ:   f <= 36'(prod >>> 16);
      OP_A_F:    f <= f - 36'(prod >>> 16);
      OP_A_ML:   acc <= 48'(prod);
      OP_A_WR: begin
        dprev <= dcur;
        pcur  <= pnext;
      end
      default: ;
    endcase
  end

  msro_ram #(.WIDTH(24), .DEPTH(MAX_WEIGHTS)) u_pos (
    .clk   (clk),
    .we    (p_we),
    .waddr (waddr),
    .wdata (p_wdata),
    .raddr (p_raddr),
    .rdata (p_rd)
  );

  msro_ram #(.WIDTH(24), .DEPTH(MAX_WEIGHTS)) u_vel (
    .clk   (clk),
    .we    (v_we),
    .waddr (waddr),
    .wdata (v_wdata),
    .raddr (v_raddr),
    .rdata (v_rd)
  );

  msro_ram #(.WIDTH(24), .DEPTH(MAX_WEIGHTS)) u_acc (
    .clk   (clk),
    .we    (a_we),
    .waddr (waddr),
    .wdata (a_wdata),
    .raddr (a_raddr),
    .rdata (a_rd)
  );

endmodule

FILE: rtl/core/msro_ctrl.sv
// Controller: sequencer for start-up fill, sample, physics, pluck and excite words.
module msro_ctrl #(
  parameter int MAX_WEIGHTS = msro_pkg::MAX_WEIGHTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           op_valid,
  output logic                           op_stall,
  input  logic [1:0]                     operation,
  output logic                           dac_valid,
  input  logic                           dac_stall,
  input  logic [$clog2(MAX_WEIGHTS)-1:0] n_m1,
  output msro_pkg::dp_cmd_t              cmd,
  output logic [$clog2(MAX_WEIGHTS)-1:0] idx
);
  import msro_pkg::*;

  localparam int IW = $clog2(MAX_WEIGHTS);
  localparam int N0 = (MAX_WEIGHTS < RING_SIZE_RST) ? MAX_WEIGHTS : RING_SIZE_RST;

  state_t        state, state_next;
  logic [IW-1:0] idx_next;
  logic [2:0]    k, k_next;
  logic          room, last, fill_last, sine_more;

  assign room      = !dac_valid || !dac_stall;
  assign last      = idx == n_m1;
  assign fill_last = idx == IW'(MAX_WEIGHTS - 1);
  assign sine_more = ((IW+1)'(idx) + (IW+1)'(1)) < (IW+1)'(N0);
  assign op_stall  = state != ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INI_START;
      idx       <= '0;
      k         <= '0;
      dac_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      k     <= k_next;
      if (state == ST_SM_OUT && room) begin
        dac_valid <= 1'b1;
      end else if (!dac_stall) begin
        dac_valid <= 1'b0;
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    idx_next   = idx;
    k_next     = k;
    unique case (state)
      ST_INI_START: begin
        idx_next   = '0;
        state_next = ST_INI_SQ;
      end
      ST_INI_SQ: state_next = ST_INI_X2;
      ST_INI_X2: begin
        k_next     = '0;
        state_next = ST_INI_TMUL;
      end
      ST_INI_TMUL: state_next = ST_INI_DIV;
      ST_INI_DIV:  state_next = ST_INI_TUPD;
      ST_INI_TUPD: begin
        if (k == 3'(SINE_TERMS - 1)) begin
          state_next = ST_INI_XT;
        end else begin
          k_next     = k + 3'd1;
          state_next = ST_INI_TMUL;
        end
      end
      ST_INI_XT: state_next = ST_INI_WR;
      ST_INI_WR, ST_INI_ZERO: begin
        if (fill_last) begin
          state_next = ST_IDLE;
        end else begin
          idx_next   = IW'(idx + 1'b1);
          state_next = sine_more ? ST_INI_SQ : ST_INI_ZERO;
        end
      end
      ST_IDLE: begin
        if (op_valid) begin
          unique case (oper_t'(operation))
            OPER_SAMPLE:  state_next = ST_SM_PTR;
            OPER_PHYSICS: begin
              idx_next   = '0;
              state_next = ST_V_RD;
            end
            OPER_PLUCK:   state_next = ST_PL_RD;
            OPER_EXCITE:  state_next = ST_EX_RD;
          endcase
        end
      end
      ST_SM_PTR: state_next = ST_SM_RDI;
      ST_SM_RDI: state_next = ST_SM_RDJ;
      ST_SM_RDJ: state_next = ST_SM_MUL;
      ST_SM_MUL: state_next = ST_SM_OUT;
      ST_SM_OUT: begin
        if (room) begin
          state_next = ST_IDLE;
        end
      end
      ST_V_RD:  state_next = ST_V_MUL;
      ST_V_MUL: state_next = ST_V_WR;
      ST_V_WR: begin
        if (last) begin
          idx_next   = '0;
          state_next = ST_P_RD;
        end else begin
          idx_next   = IW'(idx + 1'b1);
          state_next = ST_V_RD;
        end
      end
      ST_P_RD:  state_next = ST_P_MUL;
      ST_P_MUL: state_next = ST_P_WR;
      ST_P_WR: begin
        if (last) begin
          state_next = ST_A_RD0;
        end else begin
          idx_next   = IW'(idx + 1'b1);
          state_next = ST_P_RD;
        end
      end
      ST_A_RD0: state_next = ST_A_RDL;
      ST_A_RDL: state_next = ST_A_INIT;
      ST_A_INIT: begin
        idx_next   = '0;
        state_next = ST_A_RD;
      end
      ST_A_RD:   state_next = ST_A_DIFF;
      ST_A_DIFF: state_next = ST_A_MK;
      ST_A_MK:   state_next = ST_A_MZ;
      ST_A_MZ:   state_next = ST_A_F;
      ST_A_F:    state_next = ST_A_MH;
      ST_A_MH:   state_next = ST_A_ML;
      ST_A_ML:   state_next = ST_A_WR;
      ST_A_WR: begin
        if (last) begin
          state_next = ST_IDLE;
        end else begin
          idx_next   = IW'(idx + 1'b1);
          state_next = ST_A_RD;
        end
      end
      ST_PL_RD: state_next = ST_PL_WR;
      ST_PL_WR: state_next = ST_IDLE;
      ST_EX_RD: state_next = ST_EX_WR;
      ST_EX_WR: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd.k     = k;
    cmd.latch = (state == ST_IDLE) && op_valid;
    cmd.op    = OP_NOP;
    unique case (state)
      ST_INI_START: cmd.op = OP_INI_START;
      ST_INI_SQ:    cmd.op = OP_INI_SQ;
      ST_INI_X2:    cmd.op = OP_INI_X2;
      ST_INI_TMUL:  cmd.op = OP_INI_TMUL;
      ST_INI_DIV:   cmd.op = OP_INI_DIV;
      ST_INI_TUPD:  cmd.op = OP_INI_TUPD;
      ST_INI_XT:    cmd.op = OP_INI_XT;
      ST_INI_WR:    cmd.op = OP_INI_WR;
      ST_INI_ZERO:  cmd.op = OP_INI_ZERO;
      ST_SM_PTR:    cmd.op = OP_SM_PTR;
      ST_SM_RDI:    cmd.op = OP_SM_RDI;
      ST_SM_RDJ:    cmd.op = OP_SM_RDJ;
      ST_SM_MUL:    cmd.op = OP_SM_MUL;
      ST_SM_OUT:    cmd.op = room ? OP_SM_OUT : OP_NOP;
      ST_V_RD:      cmd.op = OP_V_RD;
      ST_V_MUL:     cmd.op = OP_V_MUL;
      ST_V_WR:      cmd.op = OP_V_WR;
      ST_P_RD:      cmd.op = OP_P_RD;
      ST_P_MUL:     cmd.op = OP_P_MUL;
      ST_P_WR:      cmd.op = OP_P_WR;
      ST_A_RD0:     cmd.op = OP_A_RD0;
      ST_A_RDL:     cmd.op = OP_A_RDL;
      ST_A_INIT:    cmd.op = OP_A_INIT;
      ST_A_RD:      cmd.op = OP_A_RD;
      ST_A_DIFF:    cmd.op = OP_A_DIFF;
      ST_A_MK:      cmd.op = OP_A_MK;
      ST_A_MZ:      cmd.op = OP_A_MZ;
      ST_A_F:       cmd.op = OP_A_F;
      ST_A_MH:      cmd.op = OP_A_MH;
      ST_A_ML:      cmd.op = OP_A_ML;
      ST_A_WR:      cmd.op = OP_A_WR;
      ST_PL_RD:     cmd.op = OP_PL_RD;
      ST_PL_WR:     cmd.op = OP_PL_WR;
      ST_EX_RD:     cmd.op = OP_EX_RD;
      ST_EX_WR:     cmd.op = OP_EX_WR;
      default:      cmd.op = OP_NOP;
    endcase
  end

`ifndef SYNTH
  a_term_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_INI_TUPD |-> k < 3'(SINE_TERMS))
    else $error("series term count overran");

  a_dac_hold: assert property (@(posedge clk) disable iff (rst)
    (dac_valid && dac_stall) |=> dac_valid)
    else $error("stalled output word dropped");

  a_dac_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SM_OUT && !dac_valid) |=> dac_valid)
    else $error("sample not presented");

  a_sample_start: assert property (@(posedge clk) disable iff (rst)
    (op_valid && !op_stall && operation == OPER_SAMPLE) |=> state == ST_SM_PTR)
    else $error("sample word did not start scan");
`endif

endmodule

FILE: dv/tb_mass_spring_ring_oscillator.sv
// Testbench for the mass-spring ring oscillator: directed table plus random words.
`timescale 1ns / 1ps

module tb_mass_spring_ring_oscillator;
  import msro_pkg::*;

  localparam int NMASS = 64;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int SETTLE_CYCLES = 1000;
  localparam int NUM_PHASES = 12;
  localparam int PHASE_WORDS = 155;
  localparam logic [2:0] REG_UNUSED = 3'd6;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;
  logic op_valid = 1'b0;
  logic op_stall;
  logic [1:0] operation = '0;
  logic [5:0] weight_index = '0;
  logic signed [23:0] amount = '0;
  logic dac_valid;
  logic dac_stall = 1'b0;
  logic [11:0] dac_code;

  mass_spring_ring_oscillator dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .op_valid(op_valid), .op_stall(op_stall),
    .operation(operation), .weight_index(weight_index), .amount(amount),
    .dac_valid(dac_valid), .dac_stall(dac_stall), .dac_code(dac_code)
  );

  always #5 clk = ~clk;

  // predicted state of the ring
  logic signed [23:0] pos [NMASS];
  logic signed [23:0] vel [NMASS];
  logic signed [23:0] acc [NMASS];
  logic [15:0] phase_acc;
  logic [6:0] ring_reg;
  logic [23:0] k_reg, z_reg, im_reg;
  logic [15:0] h_reg, dphase_reg;

  logic [11:0] pending_codes[$];
  int mismatches = 0;
  bit quiet = 1'b0;
  bit op_gaps = 1'b1;
  bit out_gaps = 1'b1;
  int idle_cycles = 0;

  function automatic logic signed [23:0] clamp24(longint x);
    if (x > 64'sd8388607) return 24'sh7FFFFF;
    if (x < -64'sd8388608) return 24'sh800000;
    return x[23:0];
  endfunction

  function automatic int unsigned ring_len();
    if (ring_reg < 4) return 4;
    if (ring_reg > NMASS) return NMASS;
    return ring_reg;
  endfunction

  function automatic logic signed [23:0] sine_q16(longint unsigned i, longint unsigned n);
    longint unsigned x, x2, t;
    longint unsigned dv [5];
    bit neg;
    dv = '{110, 72, 42, 20, 6};
    neg = 1'b0;
    t = 65536;
    x = (i * 408814) / n;
    if (x > 205887) begin
      x -= 205887;
      neg = 1'b1;
    end
    if (x > 102944) x = 205887 - x;
    x2 = (x * x) >> 16;
    for (int d = 0; d < 5; d++) t = 65536 - ((x2 * t) >> 16) / dv[d];
    x = (x * t) >> 16;
    return neg ? -$signed(x[23:0]) : $signed(x[23:0]);
  endfunction

  task automatic ring_reset();
    ring_reg = 7'd64;
    k_reg = 24'd131072;
    z_reg = 24'd16384;
    im_reg = 24'd1310720;
    h_reg = 16'd655;
    dphase_reg = 16'd0;
    phase_acc = '0;
    for (int i = 0; i < NMASS; i++) begin
      pos[i] = (i < ring_len()) ? sine_q16(i, ring_len()) : '0;
      vel[i] = '0;
      acc[i] = '0;
    end
  endtask

  task automatic integrate_ring();
    int unsigned n;
    longint h, d, dprev, f;
    int j;
    n = ring_len();
    h = h_reg;
    for (int i = 0; i < n; i++) vel[i] = clamp24(vel[i] + ((h * acc[i]) >>> 16));
    for (int i = 0; i < n; i++) pos[i] = clamp24(pos[i] + ((h * vel[i]) >>> 16));
    dprev = longint'(pos[0]) - pos[n-1];
    for (int i = 0; i < n; i++) begin
      j = (i + 1 == n) ? 0 : i + 1;
      d = longint'(pos[j]) - pos[i];
      f = (((d - dprev) * longint'(k_reg)) >>> 16) - ((longint'(z_reg) * vel[i]) >>> 16);
      acc[i] = clamp24((f * longint'(im_reg)) >>> 16);
      dprev = d;
    end
  endtask

  function automatic logic [11:0] scan_code();
    int unsigned n, ptr, i, j, fr;
    longint s, code;
    n = ring_len();
    ptr = phase_acc * n;
    i = ptr >> 16;
    fr = ptr & 16'hFFFF;
    j = (i + 1 == n) ? 0 : i + 1;
    s = longint'(pos[i]) + (((longint'(pos[j]) - pos[i]) * longint'(fr)) >>> 16);
    code = (s >>> 7) + 2048;
    if (code < 0) code = 0;
    if (code > 4095) code = 4095;
    phase_acc = phase_acc + dphase_reg;
    return code[11:0];
  endfunction

  task automatic send_word(oper_t o, logic [5:0] ix, logic signed [23:0] am,
                           bit typed, logic [11:0] typed_code);
    logic [11:0] c;
    op_valid <= 1'b1;
    operation <= o;
    weight_index <= ix;
    amount <= am;
    do @(posedge clk); while (op_stall);
    case (o)
      OPER_SAMPLE: begin
        c = scan_code();
        pending_codes.push_back(typed ? typed_code : c);
      end
      OPER_PHYSICS: integrate_ring();
      OPER_PLUCK: if (ix < ring_len()) pos[ix] = clamp24(longint'(pos[ix]) + am);
      default: if (ix < ring_len()) acc[ix] = clamp24(longint'(acc[ix]) + am);
    endcase
    if (!quiet && op_gaps && $urandom_range(0, 5) == 0) begin
      op_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic drain_and_settle();
    op_valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_RING_SIZE: ring_reg = val[6:0];
      REG_SPRING: k_reg = val;
      REG_DAMPING: z_reg = val;
      REG_INV_MASS: im_reg = val;
      REG_TIME_STEP: h_reg = val[15:0];
      REG_SCAN_INCR: dphase_reg = val[15:0];
      default: ;
    endcase
  endtask

  task automatic configure(int ph);
    logic [23:0] v;
    case (ph)
      0: v = 24'd64;
      1: v = 24'd4;
      2: v = 24'd0;
      3: v = 24'd127;
      4: v = 24'd65;
      5: v = 24'd3;
      default: v = 24'($urandom_range(4, 64));
    endcase
    write_reg(REG_RING_SIZE, v);
    v = (ph == 1) ? 24'd0 : (ph == 2) ? 24'hFFFFFF : 24'($urandom_range(0, 1 << 19));
    write_reg(REG_SPRING, v);
    v = (ph == 2) ? 24'd0 : (ph == 4) ? 24'hFFFFFF : 24'($urandom_range(0, 1 << 17));
    write_reg(REG_DAMPING, v);
    v = (ph == 3) ? 24'hFFFFFF : (ph == 4) ? 24'd0 : 24'($urandom_range(0, 1 << 21));
    write_reg(REG_INV_MASS, v);
    v = (ph == 5) ? 24'd65535 : (ph == 6) ? 24'd0 : 24'($urandom_range(0, 4000));
    write_reg(REG_TIME_STEP, v);
    v = (ph == 7) ? 24'd65535 : (ph == 8) ? 24'd0 : 24'($urandom_range(0, 65535));
    write_reg(REG_SCAN_INCR, v);
    write_reg(REG_UNUSED | 3'($urandom_range(0, 1)), 24'($urandom));
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  typedef struct {
    oper_t op;
    logic [5:0] idx;
    logic signed [23:0] amt;
    bit typed;
    logic [11:0] code;
  } directed_row_t;

  directed_row_t directed_rows [] = '{
    '{OPER_SAMPLE, 6'd0, 24'sd0, 1'b1, 12'd2048},
    '{OPER_PLUCK, 6'd0, 24'sh7FFFFF, 1'b0, 12'd0},
    '{OPER_SAMPLE, 6'd0, 24'sd0, 1'b1, 12'd4095},
    '{OPER_PLUCK, 6'd0, 24'sh800000, 1'b0, 12'd0},
    '{OPER_SAMPLE, 6'd63, 24'sh7FFFFF, 1'b1, 12'd2047},
    '{OPER_PLUCK, 6'd0, 24'sh800000, 1'b0, 12'd0},
    '{OPER_SAMPLE, 6'd0, 24'sd0, 1'b1, 12'd0},
    '{OPER_PLUCK, 6'd0, 24'sh7FFFFF, 1'b0, 12'd0},
    '{OPER_PLUCK, 6'd0, 24'sh7FFFFF, 1'b0, 12'd0},
    '{OPER_SAMPLE, 6'd0, 24'sd0, 1'b1, 12'd4095},
    '{OPER_PLUCK, 6'd63, 24'sh123456, 1'b0, 12'd0},
    '{OPER_EXCITE, 6'd5, 24'sh7FFFFF, 1'b0, 12'd0},
    '{OPER_EXCITE, 6'd5, 24'sh7FFFFF, 1'b0, 12'd0},
    '{OPER_EXCITE, 6'd6, 24'sh800000, 1'b0, 12'd0},
    '{OPER_EXCITE, 6'd63, 24'sh2AAAAA, 1'b0, 12'd0},
    '{OPER_PHYSICS, 6'd0, 24'sd0, 1'b0, 12'd0},
    '{OPER_SAMPLE, 6'd0, 24'sd0, 1'b0, 12'd0},
    '{OPER_PHYSICS, 6'd21, 24'sh555555, 1'b0, 12'd0},
    '{OPER_SAMPLE, 6'd42, 24'sh800000, 1'b0, 12'd0}
  };

  always @(posedge clk) begin
    if (dac_valid && !dac_stall && !rst) begin
      if (pending_codes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected dac word: dac_code=%0d", dac_code);
      end else begin
        if (dac_code !== pending_codes[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("dac_code mismatch: expected %0d, got %0d", pending_codes[0], dac_code);
        end
        void'(pending_codes.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((op_valid && !op_stall) || (dac_valid && !dac_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("tb_mass_spring_ring_oscillator NOT OK");
        $finish;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!quiet && out_gaps && $urandom_range(0, 7) == 0) begin
        dac_stall <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        dac_stall <= 1'b0;
      end
    end
  end

  initial begin
    oper_t o;
    logic signed [23:0] am;
    int r;
    ring_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i])
      send_word(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].amt,
                directed_rows[i].typed, directed_rows[i].code);
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_and_settle();
      configure(ph);
      op_gaps = (ph % 3) != 1;
      out_gaps = (ph % 4) != 2;
      for (int w = 0; w < PHASE_WORDS; w++) begin
        if (ph == NUM_PHASES - 1 && w == PHASE_WORDS / 2) quiet = 1'b1;
        r = $urandom_range(0, 99);
        o = (r < 58) ? OPER_SAMPLE : (r < 63) ? OPER_PHYSICS : (r < 81) ? OPER_PLUCK
                                                                        : OPER_EXCITE;
        case ($urandom_range(0, 3))
          0: am = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
          1: am = 24'($urandom);
          default: am = $signed(24'($urandom_range(0, 1 << 17))) - 24'sd65536;
        endcase
        send_word(o, 6'($urandom_range(0, 63)), am, 1'b0, '0);
      end
    end
    op_valid <= 1'b0;
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("tb_mass_spring_ring_oscillator OK");
    else $display("tb_mass_spring_ring_oscillator NOT OK");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/msro_pkg.sv
rtl/core/msro_ram.sv
rtl/core/msro_dp.sv
rtl/core/msro_ctrl.sv
rtl/core/mass_spring_ring_oscillator.sv
dv/tb_mass_spring_ring_oscillator.sv
